### src/bfra_pkg.sv
`timescale 1ns / 1ps
package bfra_pkg;

    localparam int ADDR_W = 64;
    localparam int LEN_W  = 48;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_POOL_SIZE = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_FIT   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;

    localparam logic [ADDR_W-1:0] RESET_POOL_BASE = 64'h0000_0001_0000_0000;
    localparam logic [LEN_W-1:0]  RESET_POOL_SIZE = 48'h0010_0000_0000;

    typedef struct packed {
        logic              op;
        logic [LEN_W-1:0]  request_size;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [2:0]        status;
        logic [LEN_W-1:0]  used_bytes;
    } rsp_t;

    typedef struct packed {
        logic [LEN_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic             free;
    } seg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_RDP,
        S_RDN,
        S_CAPN,
        S_PLAN,
        S_SHIFT,
        S_WR1,
        S_WR2,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic load;
        logic fail_bad;
        logic scan_start;
        logic scan_run;
        logic rd_prev;
        logic rd_next;
        logic cap_prev;
        logic cap_next;
        logic plan;
        logic shift_run;
        logic wr1;
        logic wr2;
        logic reply;
    } cmd_t;

    typedef struct packed {
        logic op_free;
        logic bad_size;
        logic scan_done;
        logic plan_fail;
        logic shift_done;
        logic wr2_valid;
    } sts_t;

endpackage

### src/best_fit_range_allocator_unit.sv
`timescale 1ns / 1ps
// Best-fit range allocator over one address pool.
// Request channel: drive request and pulse start while busy is low; the
// request is taken at that edge and busy stays high until the reply.
// Op allocate returns pool_base plus the offset of the smallest free
// segment that fits (lowest address on ties); op free releases the used
// segment starting at free_address and merges it with free neighbors.
// Result channel: done is high for exactly one cycle with result valid;
// the receiver cannot stall it, so it must sample result on that cycle.
// Sequence: a check, then a search that reads the table one entry at a time
// (the segment table sits in a single-ported read, single-ported write
// memory), a neighbor read for a free, then a shift of the entries that a
// split or merge moves, then the table writes (a second one only on a split).
// One request is in flight at a time.
// Config: cfg_write_en with cfg_index 0 writes pool_base, index 1 writes
// pool_size and resets the table to one free segment; write only while
// busy is low and no done is pending.
// Reset: pool_base 2^32, pool_size 2^36, one free segment, no used bytes.
module best_fit_range_allocator_unit #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bfra_pkg::req_t request,
    output logic           done,
    output bfra_pkg::rsp_t result,
    input  logic           cfg_write_en,
    input  logic           cfg_index,
    input  logic [63:0]    cfg_data
);
    import bfra_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bfra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    bfra_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .done         (done),
        .result       (result)
    );

endmodule

### src/bfra_ctrl.sv
`timescale 1ns / 1ps
module bfra_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  bfra_pkg::sts_t sts,
    output bfra_pkg::cmd_t cmd,
    output logic          busy
);
    import bfra_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!sts.op_free && sts.bad_size)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.op_free ? S_RDP : S_PLAN;
                end
            end
            S_RDP:   state_next = S_RDN;
            S_RDN:   state_next = S_CAPN;
            S_CAPN:  state_next = S_PLAN;
            S_PLAN:  state_next = sts.plan_fail ? S_REPLY : S_SHIFT;
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_WR1;
                end
            end
            S_WR1:   state_next = sts.wr2_valid ? S_WR2 : S_REPLY;
            S_WR2:   state_next = S_REPLY;
            S_REPLY: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_CHECK:
            begin
                cmd.fail_bad   = !sts.op_free && sts.bad_size;
                cmd.scan_start = 1'b1;
            end
            S_SCAN:  cmd.scan_run  = 1'b1;
            S_RDP:   cmd.rd_prev   = 1'b1;
            S_RDN:
            begin
                cmd.cap_prev = 1'b1;
                cmd.rd_next  = 1'b1;
            end
            S_CAPN:  cmd.cap_next  = 1'b1;
            S_PLAN:  cmd.plan      = 1'b1;
            S_SHIFT: cmd.shift_run = 1'b1;
            S_WR1:   cmd.wr1       = 1'b1;
            S_WR2:   cmd.wr2       = 1'b1;
            S_REPLY: cmd.reply     = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

### src/bfra_datapath.sv
`timescale 1ns / 1ps
module bfra_datapath #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bfra_pkg::req_t          request,
    input  logic                    cfg_write_en,
    input  logic                    cfg_index,
    input  logic [63:0]             cfg_data,
    input  bfra_pkg::cmd_t          cmd,
    output bfra_pkg::sts_t          sts,
    output logic                    done,
    output bfra_pkg::rsp_t          result
);
    import bfra_pkg::*;

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

    seg_t mem [MAX_SEGMENTS];
    seg_t ent_q_reg;
    logic dflt_reg;
    seg_t rd_ent;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    seg_t          wr_data;

    req_t              req_reg;
    logic [ADDR_W-1:0] pool_base_reg;
    logic [LEN_W-1:0]  pool_size_reg;
    logic [CW-1:0]     count_reg;
    logic [LEN_W-1:0]  used_reg;
    logic              init_reg;

    logic [CW-1:0]    sc_idx_reg;
    logic             ev_valid_reg;
    logic [IW-1:0]    ev_idx_reg;
    logic             found_reg;
    logic [IW-1:0]    best_idx_reg;
    logic [LEN_W-1:0] best_len_reg;
    logic [LEN_W-1:0] best_off_reg;
    logic             best_free_reg;
    seg_t             prev_reg;
    seg_t             next_reg;

    logic [IW-1:0] sh_src_reg;
    logic [CW-1:0] sh_left_reg;
    logic          sh_up_reg;
    logic [1:0]    sh_d_reg;
    logic          pend_valid_reg;
    logic [IW-1:0] pend_dst_reg;

    logic [IW-1:0]    wr1_idx_reg;
    seg_t             wr1_reg;
    logic [IW-1:0]    wr2_idx_reg;
    seg_t             wr2_reg;
    logic             wr2_valid_reg;
    logic [CW-1:0]    cnt_plan_reg;
    logic [LEN_W-1:0] used_plan_reg;

    logic              done_reg;
    rsp_t              result_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [2:0]        res_status_reg;

    logic [2:0]        p_status;
    logic [ADDR_W-1:0] p_addr;
    logic [IW-1:0]     p_src;
    logic [CW-1:0]     p_n;
    logic              p_up;
    logic [1:0]        p_d;
    logic [IW-1:0]     p_wr1_idx;
    seg_t              p_wr1;
    logic [IW-1:0]     p_wr2_idx;
    seg_t              p_wr2;
    logic              p_wr2_valid;
    logic [CW-1:0]     p_cnt;
    logic [LEN_W-1:0]  p_used;

    logic [CW-1:0] k_c;
    logic          split;
    logic          has_prev;
    logic          has_next;
    logic          ev_hit;

    assign rd_ent = dflt_reg ? seg_t'{off: '0, len: pool_size_reg, free: 1'b1} : ent_q_reg;
    assign k_c    = CW'(best_idx_reg);

    always_comb
    begin
        priority if (cmd.scan_run)
        begin
            rd_addr = sc_idx_reg[IW-1:0];
        end
        else if (cmd.rd_prev)
        begin
            rd_addr = (best_idx_reg == '0) ? best_idx_reg : best_idx_reg - IW'(1);
        end
        else if (cmd.rd_next)
        begin
            rd_addr = best_idx_reg + IW'(1);
        end
        else
        begin
            rd_addr = sh_src_reg;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pend_dst_reg;
        wr_data = rd_ent;
        priority if (pend_valid_reg)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.wr1)
        begin
            wr_en   = 1'b1;
            wr_addr = wr1_idx_reg;
            wr_data = wr1_reg;
        end
        else if (cmd.wr2)
        begin
            wr_en   = 1'b1;
            wr_addr = wr2_idx_reg;
            wr_data = wr2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        ent_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_reg <= 1'b0;
        end
        else
        begin
            dflt_reg <= init_reg && (rd_addr == '0);
        end
    end

    always_comb
    begin
        ev_hit = 1'b0;
        if (req_reg.op == OP_FREE)
        begin
            ev_hit = !found_reg &&
                     (pool_base_reg + {16'b0, rd_ent.off} == req_reg.free_address);
        end
        else
        begin
            ev_hit = rd_ent.free && (rd_ent.len >= req_reg.request_size) &&
                     (!found_reg || (rd_ent.len < best_len_reg));
        end
    end

    always_comb
    begin
        split       = best_len_reg > req_reg.request_size;
        has_prev    = (best_idx_reg != '0) && prev_reg.free;
        has_next    = ((k_c + CW'(1)) < count_reg) && next_reg.free;
        p_status    = ST_OK;
        p_addr      = '0;
        p_src       = best_idx_reg;
        p_n         = '0;
        p_up        = 1'b0;
        p_d         = 2'd1;
        p_wr1_idx   = best_idx_reg;
        p_wr1       = seg_t'{off: best_off_reg, len: best_len_reg, free: 1'b1};
        p_wr2_idx   = best_idx_reg + IW'(1);
        p_wr2       = seg_t'{off: best_off_reg + req_reg.request_size,
                             len: best_len_reg - req_reg.request_size, free: 1'b1};
        p_wr2_valid = 1'b0;
        p_cnt       = count_reg;
        p_used      = used_reg;
        if (req_reg.op == OP_ALLOC)
        begin
            priority if (!found_reg)
            begin
                p_status = ST_NO_FIT;
            end
            else if (split && (count_reg >= CNT_MAX))
            begin
                p_status = ST_FULL;
            end
            else
            begin
                p_addr      = pool_base_reg + {16'b0, best_off_reg};
                p_up        = 1'b1;
                p_src       = IW'(count_reg - CW'(1));
                p_n         = split ? (count_reg - CW'(1) - k_c) : '0;
                p_wr1       = seg_t'{off: best_off_reg,
                                     len: split ? req_reg.request_size : best_len_reg,
                                     free: 1'b0};
                p_wr2_valid = split;
                p_cnt       = count_reg + CW'(split);
                p_used      = used_reg + req_reg.request_size;
            end
        end
        else
        begin
            if (!found_reg || best_free_reg)
            begin
                p_status = ST_UNKNOWN;
            end
            else
            begin
                p_used = used_reg - best_len_reg;
                priority if (has_prev && has_next)
                begin
                    p_wr1_idx = best_idx_reg - IW'(1);
                    p_wr1     = seg_t'{off: prev_reg.off,
                                       len: prev_reg.len + best_len_reg + next_reg.len,
                                       free: 1'b1};
                    p_d       = 2'd2;
                    p_src     = best_idx_reg + IW'(2);
                    p_n       = count_reg - k_c - CW'(2);
                    p_cnt     = count_reg - CW'(2);
                end
                else if (has_prev)
                begin
                    p_wr1_idx = best_idx_reg - IW'(1);
                    p_wr1     = seg_t'{off: prev_reg.off, len: prev_reg.len + best_len_reg,
                                       free: 1'b1};
                    p_src     = best_idx_reg + IW'(1);
                    p_n       = count_reg - k_c - CW'(1);
                    p_cnt     = count_reg - CW'(1);
                end
                else if (has_next)
                begin
                    p_wr1 = seg_t'{off: best_off_reg, len: best_len_reg + next_reg.len,
                                   free: 1'b1};
                    p_src = best_idx_reg + IW'(2);
                    p_n   = count_reg - k_c - CW'(2);
                    p_cnt = count_reg - CW'(1);
                end
                else
                begin
                    p_n = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (ev_valid_reg && ev_hit)
        begin
            best_idx_reg  <= ev_idx_reg;
            best_len_reg  <= rd_ent.len;
            best_off_reg  <= rd_ent.off;
            best_free_reg <= rd_ent.free;
        end
        if (cmd.cap_prev)
        begin
            prev_reg <= rd_ent;
        end
        if (cmd.cap_next)
        begin
            next_reg <= rd_ent;
        end
        if (cmd.plan)
        begin
            sh_up_reg     <= p_up;
            sh_d_reg      <= p_d;
            wr1_idx_reg   <= p_wr1_idx;
            wr1_reg       <= p_wr1;
            wr2_idx_reg   <= p_wr2_idx;
            wr2_reg       <= p_wr2;
            cnt_plan_reg  <= p_cnt;
            used_plan_reg <= p_used;
        end
        if (cmd.fail_bad)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= ST_BAD_SIZE;
        end
        else if (cmd.plan)
        begin
            res_addr_reg   <= p_addr;
            res_status_reg <= p_status;
        end
        if (cmd.shift_run && (sh_left_reg != '0))
        begin
            pend_dst_reg <= sh_up_reg ? sh_src_reg + IW'(1) : sh_src_reg - IW'(sh_d_reg);
        end
        if (cmd.reply)
        begin
            result_reg <= rsp_t'{granted_address: res_addr_reg,
                                 status: res_status_reg, used_bytes: used_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= RESET_POOL_BASE;
            pool_size_reg  <= RESET_POOL_SIZE;
            count_reg      <= CW'(1);
            used_reg       <= '0;
            init_reg       <= 1'b1;
            sc_idx_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            ev_idx_reg     <= '0;
            found_reg      <= 1'b0;
            sh_src_reg     <= '0;
            sh_left_reg    <= '0;
            pend_valid_reg <= 1'b0;
            wr2_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.reply;
            if (wr_en && (wr_addr == '0))
            begin
                init_reg <= 1'b0;
            end
            if (cfg_write_en && (cfg_index == REG_POOL_BASE))
            begin
                pool_base_reg <= cfg_data;
            end
            if (cfg_write_en && (cfg_index == REG_POOL_SIZE))
            begin
                pool_size_reg <= cfg_data[LEN_W-1:0];
                count_reg     <= CW'(1);
                used_reg      <= '0;
                init_reg      <= 1'b1;
            end
            else if (cmd.wr1)
            begin
                count_reg <= cnt_plan_reg;
                used_reg  <= used_plan_reg;
            end
            if (cmd.scan_start)
            begin
                sc_idx_reg   <= '0;
                ev_valid_reg <= 1'b0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                ev_valid_reg <= sc_idx_reg < count_reg;
                ev_idx_reg   <= sc_idx_reg[IW-1:0];
                if (sc_idx_reg < count_reg)
                begin
                    sc_idx_reg <= sc_idx_reg + CW'(1);
                end
                if (ev_valid_reg && ev_hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            else
            begin
                ev_valid_reg <= 1'b0;
            end
            if (cmd.plan)
            begin
                sh_src_reg    <= p_src;
                sh_left_reg   <= p_n;
                wr2_valid_reg <= p_wr2_valid;
            end
            else if (cmd.shift_run && (sh_left_reg != '0))
            begin
                sh_src_reg  <= sh_up_reg ? sh_src_reg - IW'(1) : sh_src_reg + IW'(1);
                sh_left_reg <= sh_left_reg - CW'(1);
            end
            pend_valid_reg <= cmd.shift_run && (sh_left_reg != '0);
        end
    end

    assign sts.op_free    = (req_reg.op == OP_FREE);
    assign sts.bad_size   = (req_reg.request_size == '0) ||
                            (req_reg.request_size > pool_size_reg);
    assign sts.scan_done  = (sc_idx_reg == count_reg) && !ev_valid_reg;
    assign sts.plan_fail  = (p_status != ST_OK);
    assign sts.shift_done = (sh_left_reg == '0) && !pend_valid_reg;
    assign sts.wr2_valid  = wr2_valid_reg;

    assign done   = done_reg;
    assign result = result_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_MAX))
        else $error("segment count out of range");

    a_used_change: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> ($past(cmd.wr1) || $past(cfg_write_en)))
        else $error("used bytes changed outside commit");

    a_pend_from_shift: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> $past(cmd.shift_run))
        else $error("shift write without shift step");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !(cmd.wr1 || cmd.wr2))
        else $error("table write collision");

endmodule
